>>> src/mecanum_odometry_integrator_defines.svh
// Assertion macros shared by the odometry integrator RTL.
// Depends on clk and rst_n being in scope where a macro is used.
`ifndef MECANUM_ODOMETRY_INTEGRATOR_DEFINES_SVH
`define MECANUM_ODOMETRY_INTEGRATOR_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define MOI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moi assertion failed");

// Check a consequence in the cycle after its cause.
`define MOI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moi assertion failed");

`endif

>>> src/moi_pkg.sv
// Shared constants, codes, types and helper functions of the odometry integrator.
// No dependencies; used by moi_ctrl, moi_dp and the top level.
package moi_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 5;
    localparam int XY_W         = 38;
    localparam int Z_W          = 34;
    localparam int MA_W         = 35;
    localparam int MB_W         = 26;
    localparam int PROD_W       = 61;
    localparam int ACC_W        = 63;

    localparam logic signed [XY_W-1:0] GAIN_Q30 = 38'sd652032875;

    localparam logic [23:0] SCALE_RESET = 24'd133523;
    localparam logic [19:0] INV_RESET   = 20'd54613;

    // event kinds
    localparam logic [1:0] FUNC_ENC  = 2'd0;
    localparam logic [1:0] FUNC_RPM  = 2'd1;
    localparam logic [1:0] FUNC_IMU  = 2'd2;
    localparam logic [1:0] FUNC_TICK = 2'd3;

    // configuration register indexes
    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_INV   = 1'b1;

    // datapath operations
    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_LOAD   = 5'd1;
    localparam logic [4:0] OP_MUL    = 5'd2;
    localparam logic [4:0] OP_ACC    = 5'd3;
    localparam logic [4:0] OP_VINIT  = 5'd4;
    localparam logic [4:0] OP_STEP   = 5'd5;
    localparam logic [4:0] OP_VDONE  = 5'd6;
    localparam logic [4:0] OP_DIFF   = 5'd7;
    localparam logic [4:0] OP_RINITP = 5'd8;
    localparam logic [4:0] OP_PDONE  = 5'd9;
    localparam logic [4:0] OP_PADD   = 5'd10;
    localparam logic [4:0] OP_VZR    = 5'd11;
    localparam logic [4:0] OP_VZD    = 5'd12;
    localparam logic [4:0] OP_VZERO  = 5'd13;
    localparam logic [4:0] OP_RINITO = 5'd14;
    localparam logic [4:0] OP_ODONE  = 5'd15;
    localparam logic [4:0] OP_OUT    = 5'd16;

    // multiply-accumulate selections
    localparam logic [3:0] SEL_Q0 = 4'd0;
    localparam logic [3:0] SEL_Q1 = 4'd1;
    localparam logic [3:0] SEL_Q2 = 4'd2;
    localparam logic [3:0] SEL_Q3 = 4'd3;
    localparam logic [3:0] SEL_P0 = 4'd4;
    localparam logic [3:0] SEL_P1 = 4'd5;
    localparam logic [3:0] SEL_P2 = 4'd6;
    localparam logic [3:0] SEL_P3 = 4'd7;
    localparam logic [3:0] SEL_V0 = 4'd8;
    localparam logic [3:0] SEL_V1 = 4'd9;
    localparam logic [3:0] SEL_V2 = 4'd10;
    localparam logic [3:0] SEL_V3 = 4'd11;
    localparam logic [3:0] SEL_W  = 4'd12;

    typedef struct packed {
        logic [4:0]        op;
        logic [3:0]        sel;
        logic [STEP_W-1:0] step;
    } moi_cmd_t;

    typedef struct packed {
        logic ready;
        logic all_rpm;
    } moi_stat_t;

    // arctangent of 2^-i in 32-bit binary angle
    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // table angle rounded to ANGLE_BITS bits of a turn
    function automatic logic [31:0] step_angle(input logic [STEP_W-1:0] i);
        logic [4:0]  k;
        logic [32:0] t;
        k = (i > 5'd23) ? 5'd23 : i;
        t = ({1'b0, ATAN_TURNS[k]} >> (31 - ANGLE_BITS)) + 33'd1;
        return 32'((t >> 1) << (32 - ANGLE_BITS));
    endfunction

    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [31:0] r;
        if (v > 63'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -63'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> src/moi_dp.sv
// Datapath of the odometry integrator: sensor state, shared CORDIC, one shared
// multiplier with accumulators, pose and output registers. Uses moi_pkg.
module moi_dp
    import moi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  moi_cmd_t           cmd,
    output moi_stat_t          stat,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic [1:0]         func,
    input  logic [1:0]         wheel,
    input  logic signed [31:0] sample,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic signed [39:0] pos_x,
    output logic signed [39:0] pos_y,
    output logic signed [15:0] heading,
    output logic signed [15:0] orient_z,
    output logic signed [15:0] orient_w,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] yaw_rate,
    output logic               speed_valid
);

    logic [23:0] scale_reg;
    logic [19:0] inv_reg;

    logic signed [31:0] enc_latest_reg [4];
    logic signed [31:0] enc_prev_reg [4];
    logic [3:0]         enc_seen_reg;
    logic signed [31:0] rpm_reg [4];
    logic [3:0]         rpm_seen_reg;
    logic               imu_ready_reg;
    logic [15:0]        yaw_offset_reg;
    logic [15:0]        yaw_now_reg;
    logic [39:0]        acc_x_reg;
    logic [39:0]        acc_y_reg;

    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [MA_W-1:0]   dx4_reg, dy4_reg, vzr_reg;
    logic signed [MB_W-1:0]   c24_reg, s24_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc0_reg, acc1_reg, acc2_reg;

    logic signed [XY_W-1:0] crd_x_reg, crd_y_reg;
    logic signed [Z_W-1:0]  crd_z_reg;
    logic                   vec_mode_reg, flip_reg, zero_reg;

    logic [31:0] vx_reg, vy_reg, vz_reg;
    logic [15:0] oz_reg, ow_reg;

    logic [39:0] pos_x_reg, pos_y_reg;
    logic [15:0] heading_reg, orient_z_reg, orient_w_reg;
    logic [31:0] vel_x_reg, vel_y_reg, yaw_rate_reg;
    logic        speed_valid_reg;

    // CORDIC next values
    logic signed [XY_W-1:0] crd_x_next, crd_y_next;
    logic signed [Z_W-1:0]  crd_z_next;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod_w;

    logic signed [32:0]     d0, d1, d2, d3;
    logic signed [MA_W-1:0] sy_w, cy_w;
    logic [31:0]            ysum, rot_ang;
    logic [15:0]            yaw_w;
    logic signed [Z_W-1:0]  zs;
    logic signed [XY_W-1:0] cfx, cfy, c_rnd, s_rnd, oc_rnd, os_rnd;
    logic [15:0]            oz_w, ow_w;
    logic signed [ACC_W-1:0] r0_26, r1_26, r2_24;
    logic signed [PROD_W-1:0] rp16;

    assign stat.ready   = imu_ready_reg & (&enc_seen_reg);
    assign stat.all_rpm = &rpm_seen_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.sel)
            SEL_Q0: begin mul_a = MA_W'(qw_reg); mul_b = MB_W'(qz_reg); end
            SEL_Q1: begin mul_a = MA_W'(qx_reg); mul_b = MB_W'(qy_reg); end
            SEL_Q2: begin mul_a = MA_W'(qy_reg); mul_b = MB_W'(qy_reg); end
            SEL_Q3: begin mul_a = MA_W'(qz_reg); mul_b = MB_W'(qz_reg); end
            SEL_P0: begin mul_a = dx4_reg; mul_b = c24_reg; end
            SEL_P1: begin mul_a = dy4_reg; mul_b = s24_reg; end
            SEL_P2: begin mul_a = dx4_reg; mul_b = s24_reg; end
            SEL_P3: begin mul_a = dy4_reg; mul_b = c24_reg; end
            SEL_V0, SEL_V1, SEL_V2, SEL_V3:
            begin
                mul_a = MA_W'(rpm_reg[cmd.sel[1:0]]);
                mul_b = $signed({2'b00, scale_reg});
            end
            SEL_W:
            begin
                mul_a = vzr_reg;
                mul_b = $signed({6'b000000, inv_reg});
            end
            default: ;
        endcase
        prod_w = mul_a * mul_b;
    end

    // one CORDIC micro-rotation, vectoring or rotating
    always_comb
    begin
        logic signed [XY_W-1:0] xs, ys;
        logic signed [Z_W-1:0]  za;
        logic                   up;
        xs = crd_x_reg >>> cmd.step;
        ys = crd_y_reg >>> cmd.step;
        za = $signed({2'b00, step_angle(cmd.step)});
        up = vec_mode_reg ? crd_y_reg[XY_W-1] : !crd_z_reg[Z_W-1];
        if (up)
        begin
            crd_x_next = crd_x_reg - ys;
            crd_y_next = crd_y_reg + xs;
            crd_z_next = crd_z_reg - za;
        end
        else
        begin
            crd_x_next = crd_x_reg + ys;
            crd_y_next = crd_y_reg - xs;
            crd_z_next = crd_z_reg + za;
        end
    end

    // encoder differences, quaternion terms, angles and roundings
    always_comb
    begin
        d0 = 33'(enc_latest_reg[0]) - 33'(enc_prev_reg[0]);
        d1 = 33'(enc_latest_reg[1]) - 33'(enc_prev_reg[1]);
        d2 = 33'(enc_latest_reg[2]) - 33'(enc_prev_reg[2]);
        d3 = 33'(enc_latest_reg[3]) - 33'(enc_prev_reg[3]);

        sy_w = $signed({acc0_reg[33:0], 1'b0});
        cy_w = 35'sd268435456 - $signed({acc1_reg[33:0], 1'b0});

        ysum  = crd_z_reg[31:0] + 32'h0000_8000;
        yaw_w = zero_reg ? 16'h0000 : ysum[31:16];

        rot_ang = (cmd.op == OP_RINITO) ? {yaw_now_reg[15], yaw_now_reg, 15'h0000}
                                        : {yaw_now_reg, 16'h0000};
        zs = Z_W'($signed(rot_ang));

        cfx = flip_reg ? -crd_x_reg : crd_x_reg;
        cfy = flip_reg ? -crd_y_reg : crd_y_reg;
        c_rnd  = (cfx + 38'sd32) >>> 6;
        s_rnd  = (cfy + 38'sd32) >>> 6;
        oc_rnd = (cfx + 38'sd32768) >>> 16;
        os_rnd = (cfy + 38'sd32768) >>> 16;

        if (os_rnd > 38'sd16384)
            oz_w = 16'd16384;
        else if (os_rnd < -38'sd16384)
            oz_w = 16'hC000;
        else
            oz_w = os_rnd[15:0];
        if (oc_rnd > 38'sd16384)
            ow_w = 16'd16384;
        else if (oc_rnd < -38'sd16384)
            ow_w = 16'hC000;
        else
            ow_w = oc_rnd[15:0];

        r0_26 = (acc0_reg + 63'sd33554432) >>> 26;
        r1_26 = (acc1_reg + 63'sd33554432) >>> 26;
        r2_24 = (acc2_reg + 63'sd8388608) >>> 24;
        rp16  = (prod_reg + 61'sd32768) >>> 16;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            inv_reg   <= INV_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCALE: scale_reg <= cfg_data;
                CFG_INV:   inv_reg   <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // sensor state and pose accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                enc_latest_reg[i] <= '0;
                enc_prev_reg[i]   <= '0;
                rpm_reg[i]        <= '0;
            end
            enc_seen_reg   <= '0;
            rpm_seen_reg   <= '0;
            imu_ready_reg  <= 1'b0;
            yaw_offset_reg <= '0;
            yaw_now_reg    <= '0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    if (func == FUNC_ENC)
                    begin
                        if (!enc_seen_reg[wheel])
                            enc_prev_reg[wheel] <= sample;
                        enc_latest_reg[wheel] <= sample;
                        enc_seen_reg[wheel]   <= 1'b1;
                    end
                    else if (func == FUNC_RPM)
                    begin
                        rpm_reg[wheel]      <= sample;
                        rpm_seen_reg[wheel] <= 1'b1;
                    end
                end
                OP_VDONE:
                begin
                    if (!imu_ready_reg)
                    begin
                        yaw_offset_reg <= yaw_w;
                        yaw_now_reg    <= 16'h0000;
                        imu_ready_reg  <= 1'b1;
                    end
                    else
                        yaw_now_reg <= yaw_w - yaw_offset_reg;
                end
                OP_DIFF:
                begin
                    for (int i = 0; i < 4; i++)
                        enc_prev_reg[i] <= enc_latest_reg[i];
                end
                OP_PADD:
                begin
                    acc_x_reg <= acc_x_reg + r0_26[39:0];
                    acc_y_reg <= acc_y_reg + r1_26[39:0];
                end
                default: ;
            endcase
        end
    end

    // work registers: multiplier, accumulators, CORDIC
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                qw_reg <= quat_w;
                qx_reg <= quat_x;
                qy_reg <= quat_y;
                qz_reg <= quat_z;
            end
            OP_MUL:
            begin
                prod_reg <= prod_w;
                if (cmd.sel[1:0] == 2'b00)
                begin
                    acc0_reg <= '0;
                    acc1_reg <= '0;
                    acc2_reg <= '0;
                end
            end
            OP_ACC:
            begin
                case (cmd.sel)
                    SEL_Q0, SEL_Q1, SEL_P0: acc0_reg <= acc0_reg + ACC_W'(prod_reg);
                    SEL_Q2, SEL_Q3, SEL_P2, SEL_P3:
                        acc1_reg <= acc1_reg + ACC_W'(prod_reg);
                    SEL_P1: acc0_reg <= acc0_reg - ACC_W'(prod_reg);
                    SEL_V0:
                    begin
                        acc0_reg <= acc0_reg + ACC_W'(prod_reg);
                        acc1_reg <= acc1_reg - ACC_W'(prod_reg);
                        acc2_reg <= acc2_reg - ACC_W'(prod_reg);
                    end
                    SEL_V1:
                    begin
                        acc0_reg <= acc0_reg + ACC_W'(prod_reg);
                        acc1_reg <= acc1_reg + ACC_W'(prod_reg);
                        acc2_reg <= acc2_reg + ACC_W'(prod_reg);
                    end
                    SEL_V2:
                    begin
                        acc0_reg <= acc0_reg + ACC_W'(prod_reg);
                        acc1_reg <= acc1_reg + ACC_W'(prod_reg);
                        acc2_reg <= acc2_reg - ACC_W'(prod_reg);
                    end
                    SEL_V3:
                    begin
                        acc0_reg <= acc0_reg + ACC_W'(prod_reg);
                        acc1_reg <= acc1_reg - ACC_W'(prod_reg);
                        acc2_reg <= acc2_reg + ACC_W'(prod_reg);
                    end
                    default: ;
                endcase
            end
            OP_VINIT:
            begin
                vec_mode_reg <= 1'b1;
                flip_reg     <= 1'b0;
                zero_reg     <= (sy_w == '0) && (cy_w == '0);
                if (cy_w[MA_W-1])
                begin
                    crd_x_reg <= -XY_W'(cy_w);
                    crd_y_reg <= -XY_W'(sy_w);
                    crd_z_reg <= 34'sh080000000;
                end
                else
                begin
                    crd_x_reg <= XY_W'(cy_w);
                    crd_y_reg <= XY_W'(sy_w);
                    crd_z_reg <= '0;
                end
            end
            OP_STEP:
            begin
                crd_x_reg <= crd_x_next;
                crd_y_reg <= crd_y_next;
                crd_z_reg <= crd_z_next;
            end
            OP_DIFF:
            begin
                dx4_reg <= MA_W'(d0) + MA_W'(d1) + MA_W'(d2) + MA_W'(d3);
                dy4_reg <= MA_W'(d1) + MA_W'(d2) - MA_W'(d0) - MA_W'(d3);
            end
            OP_RINITP, OP_RINITO:
            begin
                vec_mode_reg <= 1'b0;
                crd_x_reg    <= GAIN_Q30;
                crd_y_reg    <= '0;
                if (zs > 34'sd1073741824)
                begin
                    crd_z_reg <= zs - 34'sd2147483648;
                    flip_reg  <= 1'b1;
                end
                else if (zs < -34'sd1073741824)
                begin
                    crd_z_reg <= zs + 34'sd2147483648;
                    flip_reg  <= 1'b1;
                end
                else
                begin
                    crd_z_reg <= zs;
                    flip_reg  <= 1'b0;
                end
            end
            OP_PDONE:
            begin
                c24_reg <= c_rnd[MB_W-1:0];
                s24_reg <= s_rnd[MB_W-1:0];
            end
            OP_VZR:
            begin
                vx_reg  <= sat32(r0_26);
                vy_reg  <= sat32(r1_26);
                vzr_reg <= r2_24[MA_W-1:0];
            end
            OP_VZD:    vz_reg <= sat32(ACC_W'(rp16));
            OP_VZERO:
            begin
                vx_reg <= '0;
                vy_reg <= '0;
                vz_reg <= '0;
            end
            OP_ODONE:
            begin
                oz_reg <= oz_w;
                ow_reg <= ow_w;
            end
            default: ;
        endcase
    end

    // result beat registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            pos_x_reg       <= acc_x_reg;
            pos_y_reg       <= acc_y_reg;
            heading_reg     <= yaw_now_reg;
            orient_z_reg    <= oz_reg;
            orient_w_reg    <= ow_reg;
            vel_x_reg       <= vx_reg;
            vel_y_reg       <= vy_reg;
            yaw_rate_reg    <= vz_reg;
            speed_valid_reg <= stat.all_rpm;
        end
    end

    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign heading     = heading_reg;
    assign orient_z    = orient_z_reg;
    assign orient_w    = orient_w_reg;
    assign vel_x       = vel_x_reg;
    assign vel_y       = vel_y_reg;
    assign yaw_rate    = yaw_rate_reg;
    assign speed_valid = speed_valid_reg;

endmodule

>>> src/moi_ctrl.sv
// Sequencer of the odometry integrator: input/output handshakes and the
// command stream for moi_dp. Uses moi_pkg and the assertion macro header.
`include "mecanum_odometry_integrator_defines.svh"

module moi_ctrl
    import moi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic [1:0] func,
    output logic      out_valid,
    input  logic      out_stall,
    input  moi_stat_t stat,
    output moi_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_QMAC   = 5'd1;
    localparam logic [4:0] S_VINIT  = 5'd2;
    localparam logic [4:0] S_VCORD  = 5'd3;
    localparam logic [4:0] S_VDONE  = 5'd4;
    localparam logic [4:0] S_DIFF   = 5'd5;
    localparam logic [4:0] S_RINITP = 5'd6;
    localparam logic [4:0] S_PCORD  = 5'd7;
    localparam logic [4:0] S_PDONE  = 5'd8;
    localparam logic [4:0] S_PMAC   = 5'd9;
    localparam logic [4:0] S_PADD   = 5'd10;
    localparam logic [4:0] S_VMAC   = 5'd11;
    localparam logic [4:0] S_VZR    = 5'd12;
    localparam logic [4:0] S_WMAC   = 5'd13;
    localparam logic [4:0] S_VZD    = 5'd14;
    localparam logic [4:0] S_VZERO  = 5'd15;
    localparam logic [4:0] S_RINITO = 5'd16;
    localparam logic [4:0] S_OCORD  = 5'd17;
    localparam logic [4:0] S_ODONE  = 5'd18;
    localparam logic [4:0] S_OUT    = 5'd19;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic [4:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              in_cord;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign in_cord   = (state_reg == S_VCORD) || (state_reg == S_PCORD) ||
                       (state_reg == S_OCORD);

    // next state and command
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg + STEP_W'(1);
        cmd.op         = OP_NOP;
        cmd.sel        = SEL_Q0;
        cmd.step       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    cmd.op = OP_LOAD;
                    if (func == FUNC_IMU)
                        state_next = S_QMAC;
                    else if (func == FUNC_TICK && stat.ready)
                        state_next = S_DIFF;
                end
            end
            S_QMAC, S_PMAC, S_VMAC:
            begin
                cmd.op  = cnt_reg[0] ? OP_ACC : OP_MUL;
                cmd.sel = {2'b00, cnt_reg[2:1]};
                if (state_reg == S_PMAC)
                    cmd.sel = SEL_P0 + {2'b00, cnt_reg[2:1]};
                else if (state_reg == S_VMAC)
                    cmd.sel = SEL_V0 + {2'b00, cnt_reg[2:1]};
                if (cnt_reg == STEP_W'(7))
                begin
                    cnt_next = '0;
                    if (state_reg == S_QMAC)
                        state_next = S_VINIT;
                    else if (state_reg == S_PMAC)
                        state_next = S_PADD;
                    else
                        state_next = S_VZR;
                end
            end
            S_VINIT:
            begin
                cmd.op     = OP_VINIT;
                cnt_next   = '0;
                state_next = S_VCORD;
            end
            S_VCORD, S_PCORD, S_OCORD:
            begin
                cmd.op = OP_STEP;
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next = '0;
                    if (state_reg == S_VCORD)
                        state_next = S_VDONE;
                    else if (state_reg == S_PCORD)
                        state_next = S_PDONE;
                    else
                        state_next = S_ODONE;
                end
            end
            S_VDONE:
            begin
                cmd.op     = OP_VDONE;
                state_next = S_IDLE;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_RINITP;
            end
            S_RINITP:
            begin
                cmd.op     = OP_RINITP;
                cnt_next   = '0;
                state_next = S_PCORD;
            end
            S_PDONE:
            begin
                cmd.op     = OP_PDONE;
                cnt_next   = '0;
                state_next = S_PMAC;
            end
            S_PADD:
            begin
                cmd.op     = OP_PADD;
                cnt_next   = '0;
                state_next = stat.all_rpm ? S_VMAC : S_VZERO;
            end
            S_VZR:
            begin
                cmd.op     = OP_VZR;
                cnt_next   = '0;
                state_next = S_WMAC;
            end
            S_WMAC:
            begin
                cmd.op  = cnt_reg[0] ? OP_NOP : OP_MUL;
                cmd.sel = SEL_W;
                if (cnt_reg[0])
                    state_next = S_VZD;
            end
            S_VZD:
            begin
                cmd.op     = OP_VZD;
                state_next = S_RINITO;
            end
            S_VZERO:
            begin
                cmd.op     = OP_VZERO;
                state_next = S_RINITO;
            end
            S_RINITO:
            begin
                cmd.op     = OP_RINITO;
                cnt_next   = '0;
                state_next = S_OCORD;
            end
            S_ODONE:
            begin
                cmd.op     = OP_ODONE;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MOI_ASSERT_NEXT(a_tick_starts, accept && func == FUNC_TICK && stat.ready, state_reg == S_DIFF)
    `MOI_ASSERT_NOW(a_beat_from_out, $rose(out_valid_reg), $past(state_reg) == S_OUT)
    `MOI_ASSERT_NOW(a_step_bound, in_cord, cnt_reg <= LAST_STEP)

endmodule

>>> src/mecanum_odometry_integrator.sv
// Top level of the mecanum wheel odometry integrator.
// Instantiates moi_ctrl and moi_dp; uses moi_pkg.
//
// Input channel (in_valid/in_stall) carries one event per beat: encoder
// distance, wheel rpm, IMU quaternion or tick. Output channel
// (out_valid/out_stall) carries one pose beat for each tick that finds the IMU
// and all four encoders ready; other events give no beat.
// Encoder and rpm events, and ticks that are not ready, finish in the accept
// cycle. An IMU event runs the accept, the quaternion multiply and accumulate
// steps, a setup step, CORDIC_STEPS vectoring steps and a write-back.
// A ready tick runs the encoder differences, two CORDIC rotations of
// CORDIC_STEPS steps each, position and velocity multiply and accumulate (or
// a velocity clear) and setup steps, all on one multiplier and one CORDIC.
// The result sits in an output register; a stalled beat holds there while the
// next events are accepted, and a following tick waits at its last step until
// that register frees up.
// Reset clears all sensor state, the pose and the output valid, and loads the
// configuration registers with their defaults. Configuration writes take
// effect at once and belong to idle periods.
module mecanum_odometry_integrator
    import moi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [1:0]         wheel,
    input  logic signed [31:0] sample,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [39:0] pos_x,
    output logic signed [39:0] pos_y,
    output logic signed [15:0] heading,
    output logic signed [15:0] orient_z,
    output logic signed [15:0] orient_w,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] yaw_rate,
    output logic               speed_valid
);

    moi_cmd_t  cmd;
    moi_stat_t stat;

    moi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    moi_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .wheel       (wheel),
        .sample      (sample),
        .quat_w      (quat_w),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading     (heading),
        .orient_z    (orient_z),
        .orient_w    (orient_w),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .yaw_rate    (yaw_rate),
        .speed_valid (speed_valid)
    );

endmodule

>>> verif/tb_mecanum_odometry_integrator.sv
// Self-checking testbench for the mecanum wheel odometry integrator.
// Predicts every pose beat from its own fixed-point odometry model; uses moi_pkg.
module tb_mecanum_odometry_integrator
    import moi_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  func;
        logic [1:0]  wheel;
        logic [31:0] sample;
        logic [15:0] qw, qx, qy, qz;
    } odo_event_t;

    typedef struct packed {
        logic [39:0] pos_x, pos_y;
        logic [15:0] heading, orient_z, orient_w;
        logic [31:0] vel_x, vel_y, yaw_rate;
        logic        speed_valid;
    } pose_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = CFG_SCALE;
    logic [23:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         func = FUNC_ENC;
    logic [1:0]         wheel = '0;
    logic signed [31:0] sample = '0;
    logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [39:0] pos_x, pos_y;
    logic signed [15:0] heading, orient_z, orient_w;
    logic signed [31:0] vel_x, vel_y, yaw_rate;
    logic               speed_valid;

    mecanum_odometry_integrator u_dut (.*);

    always #5 clk = ~clk;

    // odometry model state
    logic [23:0] scale_reg = SCALE_RESET;
    logic [19:0] inv_reg = INV_RESET;
    logic [31:0] enc_new [4], enc_old [4], rpm_val [4];
    logic        enc_have [4], rpm_have [4];
    logic        imu_have;
    logic [15:0] yaw_base, yaw_rel;
    logic [39:0] sum_x, sum_y;

    odo_event_t  pending_events [$];
    pose_beat_t  pose_expected [$];
    odo_event_t  cur_event;
    int          idle_mode = 0;
    int          hold_left = 0;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int          mismatches = 0;
    int          events_accepted = 0;
    int          poses_checked = 0;
    int          cfg_writes = 0;
    logic [31:0] enc_track [4];

    function automatic logic [31:0] rounded_step(int i);
        logic [31:0] t;
        t = ATAN_TURNS[(i > 23) ? 23 : i];
        return (((t >> (31 - ANGLE_BITS)) + 32'd1) >> 1) << (32 - ANGLE_BITS);
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    // vectoring CORDIC: binary angle of (x, y)
    function automatic logic [31:0] angle_of(longint x, longint y);
        logic [31:0] z;
        longint      xs, ys;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += rounded_step(i);
            end
            else
            begin
                x -= ys; y += xs; z -= rounded_step(i);
            end
        end
        return z;
    endfunction

    // rotation CORDIC: gain-compensated cos and sin in Q2.30
    task automatic cos_sin(input logic [31:0] ang, output longint c, output longint s);
        longint z, x, y, xs, ys, st;
        logic   flip;
        z = $signed(ang);
        x = 652032875;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1073741824)
        begin
            z -= 64'sd2147483648; flip = 1'b1;
        end
        else if (z < -64'sd1073741824)
        begin
            z += 64'sd2147483648; flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            st = longint'(rounded_step(i));
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= st;
            end
            else
            begin
                x += ys; y -= xs; z += st;
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic clear_odometry();
        for (int i = 0; i < 4; i++)
        begin
            enc_new[i] = '0; enc_old[i] = '0; rpm_val[i] = '0;
            enc_have[i] = 1'b0; rpm_have[i] = 1'b0; enc_track[i] = '0;
        end
        imu_have = 1'b0;
        yaw_base = '0;
        yaw_rel = '0;
        sum_x = '0;
        sum_y = '0;
    endtask

    // apply one accepted event, queue a pose beat for a ready tick
    task automatic advance_odometry(input odo_event_t ev);
        longint     d [4], p [4];
        longint     qw, qx, qy, qz, sy, cy, c, s, c24, s24, dx4, dy4, vz, h;
        logic [31:0] a, ang;
        logic [15:0] yaw;
        logic       ready;
        pose_beat_t pb;
        case (ev.func)
            FUNC_ENC:
            begin
                if (!enc_have[ev.wheel]) enc_old[ev.wheel] = ev.sample;
                enc_new[ev.wheel] = ev.sample;
                enc_have[ev.wheel] = 1'b1;
            end
            FUNC_RPM:
            begin
                rpm_val[ev.wheel] = ev.sample;
                rpm_have[ev.wheel] = 1'b1;
            end
            FUNC_IMU:
            begin
                qw = $signed(ev.qw); qx = $signed(ev.qx);
                qy = $signed(ev.qy); qz = $signed(ev.qz);
                sy = 2 * (qw * qz + qx * qy);
                cy = 64'sd268435456 - 2 * (qy * qy + qz * qz);
                a = angle_of(cy, sy) + 32'h8000;
                yaw = a[31:16];
                if (!imu_have)
                begin
                    yaw_base = yaw;
                    imu_have = 1'b1;
                end
                yaw_rel = yaw - yaw_base;
            end
            default:
            begin
                ready = imu_have && enc_have[0] && enc_have[1] && enc_have[2] && enc_have[3];
                if (ready)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        d[i] = longint'($signed(enc_new[i])) - longint'($signed(enc_old[i]));
                        enc_old[i] = enc_new[i];
                    end
                    dx4 = d[0] + d[1] + d[2] + d[3];
                    dy4 = -d[0] + d[1] + d[2] - d[3];
                    cos_sin({yaw_rel, 16'd0}, c, s);
                    c24 = round_shift(c, 6);
                    s24 = round_shift(s, 6);
                    sum_x = sum_x + 40'(round_shift(dx4 * c24 - dy4 * s24, 26));
                    sum_y = sum_y + 40'(round_shift(dx4 * s24 + dy4 * c24, 26));
                    pb = '0;
                    pb.speed_valid = rpm_have[0] && rpm_have[1] && rpm_have[2] && rpm_have[3];
                    if (pb.speed_valid)
                    begin
                        for (int i = 0; i < 4; i++)
                            p[i] = longint'($signed(rpm_val[i])) * longint'(scale_reg);
                        pb.vel_x = 32'(sat_word(round_shift(p[0] + p[1] + p[2] + p[3], 26)));
                        pb.vel_y = 32'(sat_word(round_shift(-p[0] + p[1] + p[2] - p[3], 26)));
                        vz = round_shift(-p[0] + p[1] - p[2] + p[3], 24);
                        pb.yaw_rate = 32'(sat_word(round_shift(vz * longint'(inv_reg), 16)));
                    end
                    h = $signed(yaw_rel);
                    ang = 32'(h * 32768);
                    cos_sin(ang, c, s);
                    pb.pos_x = sum_x;
                    pb.pos_y = sum_y;
                    pb.heading = yaw_rel;
                    pb.orient_z = 16'(clamp_unit(round_shift(s, 16)));
                    pb.orient_w = 16'(clamp_unit(round_shift(c, 16)));
                    pose_expected.push_back(pb);
                end
            end
        endcase
    endtask

    // sender: hold a stalled beat, otherwise advance to the next pending event
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                advance_odometry(cur_event);
                events_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_events.size() > 0 &&
                    !((idle_mode == 1 && $urandom_range(99) < 66) ||
                      (idle_mode == 3 && $urandom_range(99) < 14)))
                begin
                    cur_event = pending_events.pop_front();
                    in_valid <= 1'b1;
                    func <= cur_event.func;
                    wheel <= cur_event.wheel;
                    sample <= cur_event.sample;
                    quat_w <= cur_event.qw;
                    quat_x <= cur_event.qx;
                    quat_y <= cur_event.qy;
                    quat_z <= cur_event.qz;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_go && !hold_done)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    // receiver: check each pose beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                pose_beat_t got, want;
                got = '{pos_x, pos_y, heading, orient_z, orient_w,
                        vel_x, vel_y, yaw_rate, speed_valid};
                if (pose_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected pose beat %p", got);
                end
                else
                begin
                    want = pose_expected.pop_front();
                    poses_checked++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pose mismatch\n  expected %p\n  actual   %p", want, got);
                    end
                end
            end
            out_stall <= (hold_left > 0) ||
                         (idle_mode == 2 && $urandom_range(99) < 66) ||
                         (idle_mode == 3 && $urandom_range(99) < 14);
        end
    end

    function automatic odo_event_t mk(logic [1:0] f, logic [1:0] w, logic [31:0] smp,
                                      logic [15:0] qw = 0, logic [15:0] qx = 0,
                                      logic [15:0] qy = 0, logic [15:0] qz = 0);
        odo_event_t ev;
        ev.func = f; ev.wheel = w; ev.sample = smp;
        ev.qw = qw; ev.qx = qx; ev.qy = qy; ev.qz = qz;
        return ev;
    endfunction

    function automatic logic [15:0] rand_quat();
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    // random event, mostly plausible sensor traffic
    function automatic odo_event_t random_event();
        odo_event_t  ev;
        int          r;
        logic [1:0]  w;
        r = $urandom_range(99);
        w = 2'($urandom);
        if (r < 32)
        begin
            if ($urandom_range(9) == 0)
                enc_track[w] = $urandom;
            else
                enc_track[w] = enc_track[w] + 32'(int'($urandom_range(0, 2 * 40000)) - 40000);
            ev = mk(FUNC_ENC, w, enc_track[w]);
        end
        else if (r < 52)
            ev = mk(FUNC_RPM, w, ($urandom_range(9) == 0) ? $urandom :
                    32'((int'($urandom_range(0, 6000)) - 3000) * 65536 + int'($urandom_range(65535))));
        else if (r < 66)
        begin
            if ($urandom_range(19) == 0)
                ev = mk(FUNC_IMU, w, $urandom, 16'd0, 16'd0, 16'd8192, 16'd8192);
            else
                ev = mk(FUNC_IMU, w, $urandom, rand_quat(), rand_quat(), rand_quat(), rand_quat());
        end
        else if (r < 95)
            ev = mk(FUNC_TICK, w, $urandom);
        else
            ev = mk(2'($urandom), w, $urandom, 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
        return ev;
    endfunction

    task automatic wait_drained();
        while (pending_events.size() != 0 || in_valid || pose_expected.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_SCALE) scale_reg = val;
        else inv_reg = val[19:0];
        cfg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        clear_odometry();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: unready ticks, extremes, degenerate and unnormalized IMU
        pending_events.push_back(mk(FUNC_TICK, 2'd0, 32'd0));
        pending_events.push_back(mk(FUNC_ENC, 2'd0, 32'h0000_0000));
        pending_events.push_back(mk(FUNC_ENC, 2'd1, 32'h7FFF_FFFF));
        pending_events.push_back(mk(FUNC_ENC, 2'd2, 32'h8000_0000));
        pending_events.push_back(mk(FUNC_TICK, 2'd3, 32'hFFFF_FFFF));
        pending_events.push_back(mk(FUNC_ENC, 2'd3, 32'hFFFF_FFFF));
        pending_events.push_back(mk(FUNC_TICK, 2'd1, 32'd0));
        pending_events.push_back(mk(FUNC_IMU, 2'd0, 32'd0, 16'd0, 16'd0, 16'd8192, 16'd8192));
        pending_events.push_back(mk(FUNC_TICK, 2'd0, 32'd0));
        pending_events.push_back(mk(FUNC_ENC, 2'd1, 32'h8000_0000));
        pending_events.push_back(mk(FUNC_ENC, 2'd2, 32'h7FFF_FFFF));
        pending_events.push_back(mk(FUNC_RPM, 2'd0, 32'h7FFF_FFFF));
        pending_events.push_back(mk(FUNC_RPM, 2'd1, 32'h8000_0000));
        pending_events.push_back(mk(FUNC_RPM, 2'd2, 32'h7FFF_FFFF));
        pending_events.push_back(mk(FUNC_TICK, 2'd2, 32'd0));
        pending_events.push_back(mk(FUNC_RPM, 2'd3, 32'h8000_0000));
        pending_events.push_back(mk(FUNC_TICK, 2'd0, 32'd0));
        pending_events.push_back(mk(FUNC_IMU, 2'd0, 32'd0, 16'sd16384, 16'sd16384,
                                    -16'sd16384, -16'sd16384));
        pending_events.push_back(mk(FUNC_ENC, 2'd0, 32'h8000_0000));
        pending_events.push_back(mk(FUNC_TICK, 2'd0, 32'd0));
        pending_events.push_back(mk(FUNC_IMU, 2'd3, 32'd0, -16'sd16384, 16'd0, 16'd0, 16'd0));
        pending_events.push_back(mk(FUNC_RPM, 2'd1, 32'h0000_0000));
        pending_events.push_back(mk(FUNC_TICK, 2'd0, 32'd0));
        pending_events.push_back(mk(FUNC_IMU, 2'd1, 32'd0, 16'd0, 16'd0, 16'd0, 16'sd16384));
        pending_events.push_back(mk(FUNC_TICK, 2'd0, 32'd0));
        wait_drained();
        for (int i = 0; i < 4; i++) enc_track[i] = enc_new[i];

        // random phases, one register setting and idling pattern each
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_SCALE, 24'hFF_FFFF); write_reg(CFG_INV, 24'hFF_FFFF); end
                1: begin write_reg(CFG_SCALE, 24'd0); write_reg(CFG_INV, 24'd0); end
                2: begin write_reg(CFG_SCALE, 24'($urandom)); write_reg(CFG_INV, 24'($urandom)); end
                default:
                begin
                    write_reg(CFG_SCALE, SCALE_RESET);
                    write_reg(CFG_INV, {4'd0, INV_RESET});
                end
            endcase
            idle_mode = ph;
            for (int n = 0; n < 232; n++)
                pending_events.push_back(random_event());
            if (ph == 0) hold_go <= 1'b1;
            wait_drained();
        end

        $display("Accepted %0d events, checked %0d pose beats, %0d register writes,",
                 events_accepted, poses_checked, cfg_writes);
        $display("over four idling patterns and one long receiver hold-off.");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
